/* rtl/core/max_flow_capacity_scaling_defines.svh */
// Assertion macros for the max-flow block.
`ifndef MAX_FLOW_CAPACITY_SCALING_DEFINES_SVH
`define MAX_FLOW_CAPACITY_SCALING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MFCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("max flow assertion failed");

// Next-cycle implication, disabled during reset.
`define MFCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("max flow assertion failed");

`endif

/* rtl/core/mfcs_pkg.sv */
// Package with types and constants of the max-flow block.
`default_nettype none
package mfcs_pkg;
   localparam int NODES  = 64;
   localparam int EDGES  = 256;
   localparam int NODE_W = 6;
   localparam int EIDX_W = 8;
   localparam int SLOT_W = 9;
   localparam int ETOT_W = 9;
   localparam int CAP_W  = 32;
   localparam int FLOW_W = 40;
   localparam int LVL_W  = 7;
   localparam int PTR_W  = 10;
   localparam int NCNT_W = 7;

   localparam logic [1:0] CSR_SOURCE = 2'd0;
   localparam logic [1:0] CSR_SINK   = 2'd1;
   localparam logic [1:0] CSR_NODES  = 2'd2;

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;
   localparam logic RSP_FLOW  = 1'b0;
   localparam logic RSP_EDGE  = 1'b1;

   // Stack amount of the source entry: above any capacity.
   localparam logic [CAP_W:0] AMOUNT_INF = {1'b1, {CAP_W{1'b0}}};

   typedef enum logic [4:0] {
      ST_IDLE, ST_RUN_INIT, ST_ADJ_EDGE, ST_ADJ_EVAL, ST_ADJ_SELF, ST_THR_INIT,
      ST_THR_FIND, ST_PHASE, ST_BFS_INIT, ST_BFS_POP, ST_BFS_NODE, ST_BFS_NODE2,
      ST_BFS_EDGE, ST_BFS_ID, ST_BFS_CHECK, ST_BFS_DONE, ST_DFS_INIT, ST_DFS_TOP,
      ST_DFS_LOAD, ST_DFS_SCAN, ST_DFS_ID, ST_DFS_LV, ST_DFS_CHK, ST_RET,
      ST_R0_WAIT, ST_R0_INC, ST_AUG_U, ST_AUG_ADJ, ST_AUG_ID, ST_AUG_WR,
      ST_PATH_DONE, ST_FINISH
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0] from;
      logic [NODE_W-1:0] to;
      logic [CAP_W-1:0]  cap;
      logic [CAP_W-1:0]  res_fwd;
      logic [CAP_W-1:0]  res_rev;
   } edge_type;

   typedef struct packed {
      logic [PTR_W-1:0] start;
      logic [PTR_W-1:0] stop;
   } node_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [CAP_W:0]    amount;
   } stack_type;
endpackage
`default_nettype wire

/* rtl/core/max_flow_capacity_scaling.sv */
// Max-flow / min-cut engine: edge store, capacity-scaling Dinic sequencer.
`default_nettype none
`include "max_flow_capacity_scaling_defines.svh"
// Edges load one per transfer and are kept in an on-chip edge memory, each with
// its reverse residual twin. A query reads its edge entry, then registers its
// report; input is held while it is pending. The add marked tlast starts the
// flow run and input stays stalled until the flow result is out of the engine.
// The run is a sequencer around single-port synchronous memories (edges,
// adjacency, node ranges, levels, edge pointers, BFS queue, DFS stack), so its
// length depends on the graph: the adjacency build scans every edge for each
// node in use, each BFS reads the queue, range and level of each node reached
// and the adjacency and edge entry of each entry visited, each DFS step onto a
// node loads its range, level and pointer, each DFS edge probe reads adjacency,
// edge and level, and write-back rewrites one edge per path hop, per threshold.
module max_flow_capacity_scaling
   import mfcs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // edge_from[5:0], edge_to[11:6], edge_capacity[43:12], query_index[51:44]
   input  wire logic [55:0] req_tdata,
   // req_type[0]
   input  wire logic [0:0]  req_tuser,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // total_flow[39:0], edges_dropped[40], edge_flow[72:41], edge_in_cut[73]
   output logic [79:0]      rsp_tdata,
   // resp_type[0]
   output logic [0:0]       rsp_tuser
);

   state_type state_ff, state_in;

   logic [NODE_W-1:0] src_ff, src_in, snk_ff, snk_in;
   logic [NCNT_W-1:0] ncnt_ff, ncnt_in;
   logic [ETOT_W-1:0] edge_total_ff, edge_total_in;
   logic [FLOW_W-1:0] flow_sum_ff, flow_sum_in;
   logic              overflow_ff, overflow_in, graph_done_ff, graph_done_in;
   logic [NODES-1:0]  reach_ff, reach_in, visited_ff, visited_in;
   logic [NODES-1:0]  ptr_valid_ff, ptr_valid_in;
   logic              rsp_valid_ff, rsp_valid_in, qpend_ff, qpend_in, qhit_ff, qhit_in;
   logic              rsp_user_ff, rsp_user_in;
   logic [79:0]       rsp_data_ff, rsp_data_in;

   logic [NODE_W-1:0] bu_ff, bu_in;
   logic [ETOT_W-1:0] bi_ff, bi_in;
   logic [PTR_W-1:0]  pos_ff, pos_in, ustart_ff, ustart_in;
   logic [CAP_W-1:0]  maxc_ff, maxc_in, thr_ff, thr_in;
   logic              mark_ff, mark_in;
   logic [NCNT_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [PTR_W-1:0]  kk_ff, kk_in, kbase_ff, kbase_in, kend_ff, kend_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [LVL_W-1:0]  lvl_u_ff, lvl_u_in;
   logic [NODE_W-1:0] top_u_ff, top_u_in, vnode_ff, vnode_in, sp_ff, sp_in;
   logic [CAP_W:0]    top_p_ff, top_p_in, ret_ff, ret_in;
   logic [CAP_W-1:0]  vres_ff, vres_in;

   // memory ports
   edge_type          edge_mem [EDGES];
   edge_type          e_rd_ff, e_wd;
   logic              e_re, e_we;
   logic [EIDX_W-1:0] e_ra, e_wa;
   logic [SLOT_W-1:0] adj_mem [2*EDGES];
   logic [SLOT_W-1:0] a_rd_ff, a_wd, a_ra, a_wa;
   logic              a_re, a_we;
   node_type          node_mem [NODES];
   node_type          n_rd_ff, n_wd;
   logic              n_we;
   logic [NODE_W-1:0] n_ra, n_wa;
   logic              n_re;
   logic [LVL_W-1:0]  level_mem [NODES];
   logic [LVL_W-1:0]  l_rd_ff, l_wd;
   logic              l_re, l_we;
   logic [NODE_W-1:0] l_ra, l_wa;
   logic [PTR_W-1:0]  ptr_mem [NODES];
   logic [PTR_W-1:0]  p_rd_ff, p_wd;
   logic              p_re, p_we;
   logic [NODE_W-1:0] p_ra, p_wa;
   logic [NODE_W-1:0] queue_mem [NODES];
   logic [NODE_W-1:0] q_rd_ff, q_wd, q_ra, q_wa;
   logic              q_re, q_we;
   stack_type         stack_mem [NODES];
   stack_type         s_rd_ff, s_wd;
   logic              s_re, s_we;
   logic [NODE_W-1:0] s_ra, s_wa;

   logic [NCNT_W-1:0] nc;
   logic              s_ok, t_ok, accept, slot;
   logic [NODE_W-1:0] v_sel;
   logic [CAP_W-1:0]  r_sel, cmp_thr, ret32;
   logic [ETOT_W-1:0] et_eff;
   logic [PTR_W-1:0]  deg, aug_ptr;

   assign nc = (ncnt_ff < NCNT_W'(2)) ? NCNT_W'(2) :
               (ncnt_ff > NCNT_W'(NODES)) ? NCNT_W'(NODES) : ncnt_ff;
   assign s_ok = {1'b0, src_ff} < nc;
   assign t_ok = {1'b0, snk_ff} < nc;
   assign slot = a_rd_ff[0];
   assign v_sel = slot ? e_rd_ff.from : e_rd_ff.to;
   assign r_sel = slot ? e_rd_ff.res_rev : e_rd_ff.res_fwd;
   assign cmp_thr = mark_ff ? CAP_W'(1) : thr_ff;
   assign ret32 = ret_ff[CAP_W-1:0];
   assign et_eff = graph_done_ff ? '0 : edge_total_ff;
   assign deg = kend_ff - kbase_ff;
   assign aug_ptr = ptr_valid_ff[s_rd_ff.node] ? p_rd_ff : '0;

   assign req_tready = (state_ff == ST_IDLE) && !qpend_ff && (!rsp_valid_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (e_we) edge_mem[e_wa] <= e_wd;
      if (e_re) e_rd_ff <= edge_mem[e_ra];
      if (a_we) adj_mem[a_wa] <= a_wd;
      if (a_re) a_rd_ff <= adj_mem[a_ra];
      if (n_we) node_mem[n_wa] <= n_wd;
      if (n_re) n_rd_ff <= node_mem[n_ra];
      if (l_we) level_mem[l_wa] <= l_wd;
      if (l_re) l_rd_ff <= level_mem[l_ra];
      if (p_we) ptr_mem[p_wa] <= p_wd;
      if (p_re) p_rd_ff <= ptr_mem[p_ra];
      if (q_we) queue_mem[q_wa] <= q_wd;
      if (q_re) q_rd_ff <= queue_mem[q_ra];
      if (s_we) stack_mem[s_wa] <= s_wd;
      if (s_re) s_rd_ff <= stack_mem[s_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         src_ff        <= '0;
         snk_ff        <= NODE_W'(63);
         ncnt_ff       <= NCNT_W'(64);
         edge_total_ff <= '0;
         flow_sum_ff   <= '0;
         overflow_ff   <= 1'b0;
         graph_done_ff <= 1'b0;
         reach_ff      <= '0;
         visited_ff    <= '0;
         ptr_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         qpend_ff      <= 1'b0;
         thr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         src_ff        <= src_in;
         snk_ff        <= snk_in;
         ncnt_ff       <= ncnt_in;
         edge_total_ff <= edge_total_in;
         flow_sum_ff   <= flow_sum_in;
         overflow_ff   <= overflow_in;
         graph_done_ff <= graph_done_in;
         reach_ff      <= reach_in;
         visited_ff    <= visited_in;
         ptr_valid_ff  <= ptr_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         qpend_ff      <= qpend_in;
         thr_ff        <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      qhit_ff     <= qhit_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
      bu_ff       <= bu_in;
      bi_ff       <= bi_in;
      pos_ff      <= pos_in;
      ustart_ff   <= ustart_in;
      maxc_ff     <= maxc_in;
      mark_ff     <= mark_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      kk_ff       <= kk_in;
      kbase_ff    <= kbase_in;
      kend_ff     <= kend_in;
      ptr_ff      <= ptr_in;
      lvl_u_ff    <= lvl_u_in;
      top_u_ff    <= top_u_in;
      top_p_ff    <= top_p_in;
      ret_ff      <= ret_in;
      vnode_ff    <= vnode_in;
      vres_ff     <= vres_in;
      sp_ff       <= sp_in;
   end

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      snk_in        = snk_ff;
      ncnt_in       = ncnt_ff;
      edge_total_in = edge_total_ff;
      flow_sum_in   = flow_sum_ff;
      overflow_in   = overflow_ff;
      graph_done_in = graph_done_ff;
      reach_in      = reach_ff;
      visited_in    = visited_ff;
      ptr_valid_in  = ptr_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      qpend_in      = qpend_ff;
      qhit_in       = qhit_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_data_in   = rsp_data_ff;
      bu_in         = bu_ff;
      bi_in         = bi_ff;
      pos_in        = pos_ff;
      ustart_in     = ustart_ff;
      maxc_in       = maxc_ff;
      thr_in        = thr_ff;
      mark_in       = mark_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      kk_in         = kk_ff;
      kbase_in      = kbase_ff;
      kend_in       = kend_ff;
      ptr_in        = ptr_ff;
      lvl_u_in      = lvl_u_ff;
      top_u_in      = top_u_ff;
      top_p_in      = top_p_ff;
      ret_in        = ret_ff;
      vnode_in      = vnode_ff;
      vres_in       = vres_ff;
      sp_in         = sp_ff;

      e_re = 1'b0; e_ra = '0; e_we = 1'b0; e_wa = '0; e_wd = e_rd_ff;
      a_re = 1'b0; a_ra = '0; a_we = 1'b0; a_wa = '0; a_wd = '0;
      n_re = 1'b0; n_ra = '0; n_we = 1'b0; n_wa = '0; n_wd = '0;
      l_re = 1'b0; l_ra = '0; l_we = 1'b0; l_wa = '0; l_wd = '0;
      p_re = 1'b0; p_ra = '0; p_we = 1'b0; p_wa = '0; p_wd = '0;
      q_re = 1'b0; q_ra = '0; q_we = 1'b0; q_wa = '0; q_wd = '0;
      s_re = 1'b0; s_ra = '0; s_we = 1'b0; s_wa = '0; s_wd = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SOURCE: src_in = csr_wdata[NODE_W-1:0];
            CSR_SINK:   snk_in = csr_wdata[NODE_W-1:0];
            CSR_NODES:  ncnt_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      // query report: edge entry was read when the query was taken
      if (qpend_ff) begin
         qpend_in     = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_user_in  = RSP_EDGE;
         rsp_data_in  = {6'd0,
                         qhit_ff && reach_ff[e_rd_ff.from] && !reach_ff[e_rd_ff.to],
                         qhit_ff ? (e_rd_ff.cap - e_rd_ff.res_fwd) : CAP_W'(0),
                         overflow_ff, flow_sum_ff};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == REQ_QUERY) begin
                  e_re     = 1'b1;
                  e_ra     = req_tdata[51:44];
                  qhit_in  = {1'b0, req_tdata[51:44]} < edge_total_ff;
                  qpend_in = 1'b1;
               end else begin
                  // first add after a run opens a new graph
                  if (graph_done_ff) begin
                     flow_sum_in   = '0;
                     overflow_in   = 1'b0;
                     reach_in      = '0;
                     graph_done_in = 1'b0;
                  end
                  if (et_eff < ETOT_W'(EDGES)) begin
                     e_we          = 1'b1;
                     e_wa          = et_eff[EIDX_W-1:0];
                     e_wd.from     = req_tdata[5:0];
                     e_wd.to       = req_tdata[11:6];
                     e_wd.cap      = req_tdata[43:12];
                     e_wd.res_fwd  = req_tdata[43:12];
                     e_wd.res_rev  = '0;
                     edge_total_in = et_eff + ETOT_W'(1);
                  end else begin
                     edge_total_in = et_eff;
                     overflow_in   = 1'b1;
                  end
                  if (req_tlast) state_in = ST_RUN_INIT;
               end
            end
         end
         ST_RUN_INIT: begin
            reach_in    = '0;
            flow_sum_in = '0;
            maxc_in     = '0;
            bu_in       = '0;
            bi_in       = '0;
            pos_in      = '0;
            ustart_in   = '0;
            state_in    = ST_ADJ_EDGE;
         end
         ST_ADJ_EDGE: begin
            if (bi_ff == edge_total_ff) begin
               n_we = 1'b1;
               n_wa = bu_ff;
               n_wd = '{start: ustart_ff, stop: pos_ff};
               if ({1'b0, bu_ff} == nc - NCNT_W'(1)) begin
                  state_in = ST_THR_INIT;
               end else begin
                  bu_in     = bu_ff + NODE_W'(1);
                  bi_in     = '0;
                  ustart_in = pos_ff;
               end
            end else begin
               e_re     = 1'b1;
               e_ra     = bi_ff[EIDX_W-1:0];
               state_in = ST_ADJ_EVAL;
            end
         end
         ST_ADJ_EVAL: begin
            if (bu_ff == '0 && e_rd_ff.cap > maxc_ff) maxc_in = e_rd_ff.cap;
            bi_in    = bi_ff + ETOT_W'(1);
            state_in = ST_ADJ_EDGE;
            if ({1'b0, e_rd_ff.from} < nc && {1'b0, e_rd_ff.to} < nc) begin
               if (e_rd_ff.from == bu_ff) begin
                  a_we   = 1'b1;
                  a_wa   = pos_ff[SLOT_W-1:0];
                  a_wd   = {bi_ff[EIDX_W-1:0], 1'b0};
                  pos_in = pos_ff + PTR_W'(1);
                  if (e_rd_ff.to == bu_ff) begin
                     bi_in    = bi_ff;
                     state_in = ST_ADJ_SELF;
                  end
               end else if (e_rd_ff.to == bu_ff) begin
                  a_we   = 1'b1;
                  a_wa   = pos_ff[SLOT_W-1:0];
                  a_wd   = {bi_ff[EIDX_W-1:0], 1'b1};
                  pos_in = pos_ff + PTR_W'(1);
               end
            end
         end
         ST_ADJ_SELF: begin
            // self loop: twin slot follows the forward slot
            a_we     = 1'b1;
            a_wa     = pos_ff[SLOT_W-1:0];
            a_wd     = {bi_ff[EIDX_W-1:0], 1'b1};
            pos_in   = pos_ff + PTR_W'(1);
            bi_in    = bi_ff + ETOT_W'(1);
            state_in = ST_ADJ_EDGE;
         end
         ST_THR_INIT: begin
            thr_in   = {1'b1, {(CAP_W-1){1'b0}}};
            state_in = ST_THR_FIND;
         end
         ST_THR_FIND: begin
            if (thr_ff == '0 || thr_ff <= maxc_ff) begin
               if (s_ok && t_ok && src_ff != snk_ff) state_in = ST_PHASE;
               else if (s_ok) begin
                  mark_in  = 1'b1;
                  state_in = ST_BFS_INIT;
               end else state_in = ST_FINISH;
            end else thr_in = thr_ff >> 1;
         end
         ST_PHASE: begin
            mark_in  = (thr_ff == '0);
            state_in = ST_BFS_INIT;
         end
         ST_BFS_INIT: begin
            visited_in = '0;
            visited_in[src_ff] = 1'b1;
            l_we     = 1'b1;
            l_wa     = src_ff;
            l_wd     = '0;
            q_we     = 1'b1;
            q_wa     = '0;
            q_wd     = src_ff;
            head_in  = '0;
            tail_in  = NCNT_W'(1);
            state_in = ST_BFS_POP;
         end
         ST_BFS_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_BFS_DONE;
            end else begin
               q_re     = 1'b1;
               q_ra     = head_ff[NODE_W-1:0];
               head_in  = head_ff + NCNT_W'(1);
               state_in = ST_BFS_NODE;
            end
         end
         ST_BFS_NODE: begin
            n_re     = 1'b1;
            n_ra     = q_rd_ff;
            l_re     = 1'b1;
            l_ra     = q_rd_ff;
            state_in = ST_BFS_NODE2;
         end
         ST_BFS_NODE2: begin
            kk_in    = n_rd_ff.start;
            kend_in  = n_rd_ff.stop;
            lvl_u_in = l_rd_ff;
            state_in = ST_BFS_EDGE;
         end
         ST_BFS_EDGE: begin
            if (kk_ff == kend_ff) begin
               state_in = ST_BFS_POP;
            end else begin
               a_re     = 1'b1;
               a_ra     = kk_ff[SLOT_W-1:0];
               state_in = ST_BFS_ID;
            end
         end
         ST_BFS_ID: begin
            e_re     = 1'b1;
            e_ra     = a_rd_ff[SLOT_W-1:1];
            state_in = ST_BFS_CHECK;
         end
         ST_BFS_CHECK: begin
            if (r_sel >= cmp_thr && !visited_ff[v_sel]) begin
               visited_in[v_sel] = 1'b1;
               l_we    = 1'b1;
               l_wa    = v_sel;
               l_wd    = lvl_u_ff + LVL_W'(1);
               q_we    = 1'b1;
               q_wa    = tail_ff[NODE_W-1:0];
               q_wd    = v_sel;
               tail_in = tail_ff + NCNT_W'(1);
            end
            kk_in    = kk_ff + PTR_W'(1);
            state_in = ST_BFS_EDGE;
         end
         ST_BFS_DONE: begin
            if (mark_ff) begin
               reach_in = visited_ff;
               state_in = ST_FINISH;
            end else if (!visited_ff[snk_ff]) begin
               thr_in   = thr_ff >> 1;
               state_in = ST_PHASE;
            end else begin
               ptr_valid_in = '0;
               state_in     = ST_DFS_INIT;
            end
         end
         ST_DFS_INIT: begin
            sp_in    = '0;
            top_u_in = src_ff;
            top_p_in = AMOUNT_INF;
            state_in = ST_DFS_TOP;
         end
         ST_DFS_TOP: begin
            if (top_p_ff == '0) begin
               ret_in   = '0;
               state_in = ST_RET;
            end else if (top_u_ff == snk_ff) begin
               ret_in   = top_p_ff;
               state_in = ST_RET;
            end else begin
               n_re     = 1'b1;
               n_ra     = top_u_ff;
               l_re     = 1'b1;
               l_ra     = top_u_ff;
               p_re     = 1'b1;
               p_ra     = top_u_ff;
               state_in = ST_DFS_LOAD;
            end
         end
         ST_DFS_LOAD: begin
            kbase_in = n_rd_ff.start;
            kend_in  = n_rd_ff.stop;
            lvl_u_in = l_rd_ff;
            ptr_in   = ptr_valid_ff[top_u_ff] ? p_rd_ff : '0;
            state_in = ST_DFS_SCAN;
         end
         ST_DFS_SCAN: begin
            if (ptr_ff >= deg) begin
               // dead end: keep the pointer, retreat
               p_we     = 1'b1;
               p_wa     = top_u_ff;
               p_wd     = ptr_ff;
               ptr_valid_in[top_u_ff] = 1'b1;
               ret_in   = '0;
               state_in = ST_RET;
            end else begin
               a_re     = 1'b1;
               a_ra     = SLOT_W'(kbase_ff + ptr_ff);
               state_in = ST_DFS_ID;
            end
         end
         ST_DFS_ID: begin
            e_re     = 1'b1;
            e_ra     = a_rd_ff[SLOT_W-1:1];
            state_in = ST_DFS_LV;
         end
         ST_DFS_LV: begin
            vnode_in = v_sel;
            vres_in  = r_sel;
            l_re     = 1'b1;
            l_ra     = v_sel;
            state_in = ST_DFS_CHK;
         end
         ST_DFS_CHK: begin
            if (visited_ff[vnode_ff] && l_rd_ff == lvl_u_ff + LVL_W'(1)) begin
               p_we     = 1'b1;
               p_wa     = top_u_ff;
               p_wd     = ptr_ff;
               ptr_valid_in[top_u_ff] = 1'b1;
               s_we     = 1'b1;
               s_wa     = sp_ff;
               s_wd     = '{node: top_u_ff, amount: top_p_ff};
               sp_in    = sp_ff + NODE_W'(1);
               top_u_in = vnode_ff;
               top_p_in = (top_p_ff < {1'b0, vres_ff}) ? top_p_ff : {1'b0, vres_ff};
               state_in = ST_DFS_TOP;
            end else begin
               ptr_in   = ptr_ff + PTR_W'(1);
               state_in = ST_DFS_SCAN;
            end
         end
         ST_RET: begin
            if (sp_ff == '0) begin
               state_in = ST_PATH_DONE;
            end else begin
               s_re     = 1'b1;
               s_ra     = sp_ff - NODE_W'(1);
               sp_in    = sp_ff - NODE_W'(1);
               state_in = (ret_ff == '0) ? ST_R0_WAIT : ST_AUG_U;
            end
         end
         ST_R0_WAIT: begin
            top_u_in = s_rd_ff.node;
            top_p_in = s_rd_ff.amount;
            p_re     = 1'b1;
            p_ra     = s_rd_ff.node;
            state_in = ST_R0_INC;
         end
         ST_R0_INC: begin
            // failed child: advance the parent's pointer
            p_we     = 1'b1;
            p_wa     = top_u_ff;
            p_wd     = (ptr_valid_ff[top_u_ff] ? p_rd_ff : '0) + PTR_W'(1);
            ptr_valid_in[top_u_ff] = 1'b1;
            state_in = ST_DFS_TOP;
         end
         ST_AUG_U: begin
            n_re     = 1'b1;
            n_ra     = s_rd_ff.node;
            p_re     = 1'b1;
            p_ra     = s_rd_ff.node;
            state_in = ST_AUG_ADJ;
         end
         ST_AUG_ADJ: begin
            a_re     = 1'b1;
            a_ra     = SLOT_W'(n_rd_ff.start + aug_ptr);
            state_in = ST_AUG_ID;
         end
         ST_AUG_ID: begin
            e_re     = 1'b1;
            e_ra     = a_rd_ff[SLOT_W-1:1];
            state_in = ST_AUG_WR;
         end
         ST_AUG_WR: begin
            e_we = 1'b1;
            e_wa = a_rd_ff[SLOT_W-1:1];
            e_wd = e_rd_ff;
            if (!slot) begin
               e_wd.res_fwd = e_rd_ff.res_fwd - ret32;
               e_wd.res_rev = e_rd_ff.res_rev + ret32;
            end else begin
               e_wd.res_rev = e_rd_ff.res_rev - ret32;
               e_wd.res_fwd = e_rd_ff.res_fwd + ret32;
            end
            if (sp_ff == '0) begin
               state_in = ST_PATH_DONE;
            end else begin
               s_re     = 1'b1;
               s_ra     = sp_ff - NODE_W'(1);
               sp_in    = sp_ff - NODE_W'(1);
               state_in = ST_AUG_U;
            end
         end
         ST_PATH_DONE: begin
            if (ret_ff == '0) begin
               state_in = ST_PHASE;
            end else begin
               flow_sum_in = flow_sum_ff + FLOW_W'(ret_ff);
               state_in    = ST_DFS_INIT;
            end
         end
         ST_FINISH: begin
            graph_done_in = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_user_in   = RSP_FLOW;
            rsp_data_in   = {6'd0, 1'b0, CAP_W'(0), overflow_ff, flow_sum_ff};
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `MFCS_ASSERT_NOW(a_qpend_slot_free, clock, reset, qpend_ff, !rsp_valid_ff)
   `MFCS_ASSERT_NOW(a_bfs_queue_order, clock, reset, state_ff == ST_BFS_POP, head_ff <= tail_ff)
   `MFCS_ASSERT_NEXT(a_finish_result, clock, reset, state_ff == ST_FINISH, rsp_valid_ff && (rsp_user_ff == RSP_FLOW))

endmodule
`default_nettype wire

/* tb/sv/max_flow_capacity_scaling_tb.sv */
// Testbench for the max-flow block: random graphs, queries, and an edge-by-edge flow check.
module max_flow_capacity_scaling_tb;
   import mfcs_pkg::*;

   typedef struct {
      logic       kind;
      bit [5:0]   from;
      bit [5:0]   to;
      bit [31:0]  cap;
      bit         last;
      bit [7:0]   qidx;
   } req_t;

   typedef struct {
      logic       kind;
      bit [39:0]  total;
      bit         dropped;
      bit [31:0]  eflow;
      bit         cut;
   } rsp_t;

   class flow_scoreboard;
      bit [5:0] src_node, snk_node;
      bit [6:0] ncount;
      bit [5:0] tail_of[512], head_of[512];
      longint unsigned resid[512];
      longint unsigned fwd_cap[256];
      int adj[512], adj_start[65], level[64], eptr[64], bfsq[64], stk_node[65];
      longint unsigned stk_amt[65];
      bit reach[64];
      int etotal;
      bit [39:0] fsum;
      bit dropped, done;
      rsp_t pending[$];
      int errors;

      function new();
         src_node = 0; snk_node = 63; ncount = 64;
         for (int k = 0; k < 64; k++) begin
            level[k] = -1; eptr[k] = 0; reach[k] = 0;
         end
         etotal = 0; fsum = 0; dropped = 0; done = 0; errors = 0;
      endfunction

      function void set_reg(bit [1:0] idx, bit [6:0] v);
         case (idx)
            CSR_SOURCE: src_node = v[5:0];
            CSR_SINK:   snk_node = v[5:0];
            CSR_NODES:  ncount = v;
            default: ;
         endcase
      endfunction

      function int nodes_used();
         if (ncount < 2) return 2;
         if (ncount > 64) return 64;
         return ncount;
      endfunction

      function void build_adjacency(int nc);
         int cnt[65];
         int u;
         for (int k = 0; k <= 64; k++) cnt[k] = 0;
         for (int i = 0; i < 2 * etotal; i++)
            if (tail_of[i] < nc && head_of[i] < nc) cnt[tail_of[i] + 1]++;
         adj_start[0] = 0;
         for (int i = 1; i <= nc; i++) adj_start[i] = adj_start[i - 1] + cnt[i];
         for (int k = 0; k <= 64; k++) cnt[k] = 0;
         for (int i = 0; i < 2 * etotal; i++) begin
            u = tail_of[i];
            if (u < nc && head_of[i] < nc) begin
               adj[adj_start[u] + cnt[u]] = i;
               cnt[u]++;
            end
         end
      endfunction

      function void level_bfs(int nc, longint unsigned thr, bit mark);
         int qh, qt, u, id, v;
         qh = 0; qt = 0;
         for (int k = 0; k < 64; k++) level[k] = -1;
         level[src_node] = 0;
         bfsq[qt++] = src_node;
         while (qh < qt) begin
            u = bfsq[qh++];
            for (int k = adj_start[u]; k < adj_start[u + 1]; k++) begin
               id = adj[k];
               v = head_of[id];
               if (resid[id] < thr || level[v] != -1) continue;
               level[v] = level[u] + 1;
               if (qt < 64) bfsq[qt++] = v;
            end
         end
         if (mark)
            for (int k = 0; k < nc; k++) reach[k] = (level[k] != -1);
      endfunction

      // Walk one augmenting path on the level graph; returns the amount pushed.
      function longint unsigned push_path();
         int sp, u, v, id, deg;
         longint unsigned p, r, amt;
         bit went;
         sp = 0;
         stk_node[0] = src_node;
         stk_amt[0] = 64'd1000000000000000000;
         forever begin
            u = stk_node[sp];
            p = stk_amt[sp];
            if (p == 0) amt = 0;
            else if (u == snk_node) amt = p;
            else begin
               went = 0;
               deg = adj_start[u + 1] - adj_start[u];
               while (eptr[u] < deg) begin
                  id = adj[adj_start[u] + eptr[u]];
                  v = head_of[id];
                  if (level[u] + 1 == level[v] && sp + 1 <= 64) begin
                     r = resid[id];
                     sp++;
                     stk_node[sp] = v;
                     stk_amt[sp] = (p < r) ? p : r;
                     went = 1;
                     break;
                  end
                  eptr[u]++;
               end
               if (went) continue;
               amt = 0;
            end
            if (sp == 0) return amt;
            sp--;
            u = stk_node[sp];
            if (amt == 0) begin
               eptr[u]++;
               continue;
            end
            forever begin
               id = adj[adj_start[u] + eptr[u]];
               resid[id] -= amt;
               resid[id ^ 1] += amt;
               if (sp == 0) return amt;
               sp--;
               u = stk_node[sp];
            end
         end
      endfunction

      function void run_flow();
         int nc;
         longint unsigned maxc, d, thr, f;
         nc = nodes_used();
         maxc = 0; d = 1;
         build_adjacency(nc);
         for (int k = 0; k < 64; k++) reach[k] = 0;
         fsum = 0;
         for (int i = 0; i < etotal; i++) if (fwd_cap[i] > maxc) maxc = fwd_cap[i];
         while (d <= maxc) d = d << 1;
         d = d >> 1;
         if (src_node < nc && snk_node < nc && src_node != snk_node) begin
            for (thr = d; thr > 0; thr = thr >> 1) begin
               forever begin
                  level_bfs(nc, thr, 0);
                  if (level[snk_node] == -1) break;
                  for (int k = 0; k < 64; k++) eptr[k] = 0;
                  f = push_path();
                  while (f != 0) begin
                     fsum = fsum + f[39:0];
                     f = push_path();
                  end
               end
            end
         end
         if (src_node < nc) level_bfs(nc, 1, 1);
         done = 1;
      endfunction

      function void note_input(req_t r);
         rsp_t e;
         longint unsigned fl;
         if (r.kind == REQ_ADD) begin
            if (done) begin
               etotal = 0; fsum = 0; dropped = 0; done = 0;
               for (int k = 0; k < 64; k++) reach[k] = 0;
            end
            if (etotal < 256) begin
               fwd_cap[etotal] = r.cap;
               tail_of[2 * etotal] = r.from; head_of[2 * etotal] = r.to;
               resid[2 * etotal] = r.cap;
               tail_of[2 * etotal + 1] = r.to; head_of[2 * etotal + 1] = r.from;
               resid[2 * etotal + 1] = 0;
               etotal++;
            end else
               dropped = 1;
            if (!r.last) return;
            run_flow();
            e.kind = RSP_FLOW; e.total = fsum; e.dropped = dropped;
            e.eflow = 0; e.cut = 0;
         end else begin
            e.kind = RSP_EDGE; e.total = fsum; e.dropped = dropped;
            e.eflow = 0; e.cut = 0;
            if (r.qidx < etotal) begin
               fl = fwd_cap[r.qidx] - resid[2 * r.qidx];
               e.eflow = fl[31:0];
               e.cut = reach[tail_of[2 * r.qidx]] && !reach[head_of[2 * r.qidx]];
            end
         end
         pending.insert(pending.size(), e);
      endfunction

      function void check(rsp_t a);
         rsp_t e;
         if (pending.size() == 0) begin
            $display("%0t: result expected none actual kind=%0d total=%0d",
                     $time, a.kind, a.total);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.kind != e.kind) begin
            $display("%0t: resp_type expected %0d actual %0d", $time, e.kind, a.kind);
            errors++;
         end
         if (a.total != e.total) begin
            $display("%0t: total_flow expected %0d actual %0d", $time, e.total, a.total);
            errors++;
         end
         if (a.dropped != e.dropped) begin
            $display("%0t: edges_dropped expected %0d actual %0d", $time, e.dropped, a.dropped);
            errors++;
         end
         if (a.eflow != e.eflow) begin
            $display("%0t: edge_flow expected %0d actual %0d", $time, e.eflow, a.eflow);
            errors++;
         end
         if (a.cut != e.cut) begin
            $display("%0t: edge_in_cut expected %0d actual %0d", $time, e.cut, a.cut);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [6:0]  csr_wdata;
   logic        req_tvalid, req_tready, req_tlast;
   logic [55:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [79:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   flow_scoreboard sb = new();
   int items_sent = 0;

   max_flow_capacity_scaling dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int send_idle_pct();
      if (items_sent < 430) return 20;
      if (items_sent < 860) return 75;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (items_sent < 430) return 75;
      if (items_sent < 860) return 20;
      return 0;
   endfunction

   always @(negedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct());

   always @(posedge clock) begin
      rsp_t a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.kind = rsp_tuser[0];
         a.total = rsp_tdata[39:0];
         a.dropped = rsp_tdata[40];
         a.eflow = rsp_tdata[72:41];
         a.cut = rsp_tdata[73];
         sb.check(a);
      end
   end

   task automatic send_item(req_t r);
      forever begin
         @(negedge clock);
         if ($urandom_range(99) < send_idle_pct()) req_tvalid <= 1'b0;
         else break;
      end
      req_tvalid <= 1'b1;
      req_tuser[0] <= r.kind;
      req_tlast <= r.last;
      req_tdata <= {4'b0, r.qidx, r.cap, r.to, r.from};
      do @(posedge clock); while (!req_tready);
      sb.note_input(r);
      items_sent++;
   endtask

   task automatic load_edge(bit [5:0] f, bit [5:0] t, bit [31:0] c, bit last);
      req_t r;
      r.kind = REQ_ADD; r.from = f; r.to = t; r.cap = c; r.last = last;
      r.qidx = $urandom_range(255);
      send_item(r);
   endtask

   task automatic query_edge(bit [7:0] q, bit last);
      req_t r;
      r.kind = REQ_QUERY; r.qidx = q; r.last = last;
      r.from = $urandom_range(63); r.to = $urandom_range(63); r.cap = $urandom();
      send_item(r);
   endtask

   // Hold input until every expected result is back and the engine has settled.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, bit [6:0] v);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   task automatic setup(bit [5:0] s, bit [5:0] t, bit [6:0] n);
      write_reg(CSR_SOURCE, s);
      write_reg(CSR_SINK, t);
      write_reg(CSR_NODES, n);
   endtask

   task automatic random_graph();
      int nc, ne, nq, cmax;
      bit [5:0] s, t;
      bit [31:0] c;
      nc = ($urandom_range(9) == 0) ? 64 : $urandom_range(8, 2);
      s = $urandom_range(nc - 1);
      t = $urandom_range(nc - 1);
      if ($urandom_range(19) == 0) t = s;
      if ($urandom_range(19) == 0) s = $urandom_range(63);
      case ($urandom_range(9))
         0: setup(s, t, $urandom_range(127));
         default: setup(s, t, nc);
      endcase
      cmax = $urandom_range(3);
      ne = $urandom_range(14, 1);
      for (int i = 0; i < ne; i++) begin
         case (cmax)
            0: c = $urandom();
            1: c = $urandom_range(255);
            2: c = $urandom_range(3);
            default: c = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(15);
         endcase
         if ($urandom_range(9) == 0) query_edge($urandom_range(255), $urandom_range(1));
         if ($urandom_range(11) == 0)
            load_edge($urandom_range(63), $urandom_range(63), c, i == ne - 1);
         else
            load_edge($urandom_range(nc - 1), $urandom_range(nc - 1), c, i == ne - 1);
      end
      nq = $urandom_range(12, 3);
      for (int i = 0; i < nq; i++) begin
         if ($urandom_range(7) == 0) query_edge($urandom_range(255), $urandom_range(1));
         else query_edge($urandom_range(ne + 1), $urandom_range(1));
         if (i == 1 && $urandom_range(3) == 0) drain();
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_tvalid = 1'b0; req_tlast = 1'b0; req_tdata = '0; req_tuser = '0;
      rsp_tready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Queries before any run, then a small graph at reset settings.
      query_edge(8'd0, 1'b0);
      query_edge(8'd5, 1'b1);
      load_edge(6'd0, 6'd63, 32'hFFFF_FFFF, 1'b0);
      load_edge(6'd0, 6'd1, 32'd0, 1'b0);
      load_edge(6'd1, 6'd63, 32'd5, 1'b0);
      load_edge(6'd0, 6'd1, 32'd7, 1'b0);
      load_edge(6'd2, 6'd2, 32'd3, 1'b0);
      load_edge(6'd63, 6'd0, 32'd1, 1'b1);
      for (int q = 0; q <= 6; q++) query_edge(q, 1'b0);
      query_edge(8'd255, 1'b1);
      drain();

      // Source equals sink, node count above range.
      setup(6'd5, 6'd5, 7'd127);
      load_edge(6'd5, 6'd6, 32'd9, 1'b1);
      query_edge(8'd0, 1'b0);
      drain();

      // Node count below range; an edge to an unused node.
      setup(6'd0, 6'd1, 7'd0);
      load_edge(6'd0, 6'd1, 32'd1, 1'b0);
      load_edge(6'd0, 6'd40, 32'd8, 1'b1);
      query_edge(8'd0, 1'b0);
      query_edge(8'd1, 1'b0);
      drain();

      // Source out of use.
      setup(6'd63, 6'd1, 7'd10);
      load_edge(6'd0, 6'd1, 32'd4, 1'b1);
      query_edge(8'd0, 1'b0);
      drain();

      // Overfill the edge store.
      setup(6'd0, 6'd3, 7'd4);
      for (int i = 0; i < 258; i++)
         load_edge($urandom_range(3), $urandom_range(3), $urandom_range(7), i == 257);
      query_edge(8'd255, 1'b0);
      query_edge(8'd0, 1'b0);
      for (int i = 0; i < 6; i++) query_edge($urandom_range(255), 1'b0);
      drain();

      while (items_sent < 1300) random_graph();

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mfcs_pkg.sv
rtl/core/max_flow_capacity_scaling.sv
tb/sv/max_flow_capacity_scaling_tb.sv
